### hdl/pvm_pkg.sv
// Shared constants, the arctangent table and item types for the velocity modulation core.
package pvm_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int STAGES        = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

  // CORDIC datapath width: Q4.30 values and the pi/2^31 angle accumulator
  localparam int XW = 34;
  // c and s in Q2.14 with headroom
  localparam int CW = 18;
  // c*c, s*s, c*s
  localparam int PW = 30;
  // matrix entries
  localparam int MW = 48;

  localparam logic signed [XW-1:0] X_INIT = 34'sh26DD3B6A;

  localparam logic signed [XW-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
    34'sh20000000, 34'sh12E4051E, 34'sh09FB385B, 34'sh051111D4,
    34'sh028B0D43, 34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55,
    34'sh0028BE53, 34'sh00145F2F, 34'sh000A2F98, 34'sh000517CC,
    34'sh00028BE6, 34'sh000145F3, 34'sh0000A2FA, 34'sh0000517D,
    34'sh000028BE, 34'sh0000145F, 34'sh00000A30, 34'sh00000518,
    34'sh0000028C, 34'sh00000146, 34'sh000000A3, 34'sh00000051
  };

  // cordic stage registers + c/s rounding + five arithmetic stages
  localparam int BACK_LAT  = STAGES + 7;
  localparam int OUT_AW    = $clog2(BACK_LAT + 2);
  localparam int OUT_DEPTH = 1 << OUT_AW;

  localparam int Q_AW    = 2;
  localparam int Q_DEPTH = 1 << Q_AW;

  typedef struct packed {
    logic signed [15:0] ang;
    logic               flip;
    logic signed [15:0] gn;
    logic signed [15:0] gt;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic               sat;
  } res_t;

  typedef struct packed {
    logic valid;
  } qctl_t;

endpackage

### hdl/pvm_front.sv
// Front end: accept items, fold the angle into the right half plane, queue them.
module pvm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] angle,
  input  logic signed [15:0] gain_normal,
  input  logic signed [15:0] gain_tangent,
  input  logic signed [15:0] speed_x,
  input  logic signed [15:0] speed_y,
  input  logic               q_pop,
  output pvm_pkg::qctl_t     q_ctl,
  output pvm_pkg::cmd_t      q_item
);
  import pvm_pkg::*;

  cmd_t             mem [Q_DEPTH];
  logic [Q_AW-1:0]  wptr;
  logic [Q_AW-1:0]  rptr;
  logic [Q_AW:0]    cnt;
  logic signed [16:0] a_ext;
  logic signed [16:0] red;
  logic             flip;
  logic             acc;
  logic             take;

  always_comb begin
    a_ext = {angle[15], angle};
    red   = a_ext;
    flip  = 1'b0;
    if (angle > 16'sd16384) begin
      red  = a_ext - 17'sd32768;
      flip = 1'b1;
    end else if (angle < -16'sd16384) begin
      red  = a_ext + 17'sd32768;
      flip = 1'b1;
    end
  end

  assign full   = (cnt == (Q_AW+1)'(Q_DEPTH));
  assign acc    = push && !full;
  assign take   = q_pop && (cnt != '0);
  assign q_ctl.valid = (cnt != '0);
  assign q_item = mem[rptr];

  always_ff @(posedge clk) begin
    if (acc) begin
      mem[wptr] <= '{ang: red[15:0], flip: flip, gn: gain_normal, gt: gain_tangent,
                     vx: speed_x, vy: speed_y};
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (acc)  wptr <= wptr + 1'b1;
      if (take) rptr <= rptr + 1'b1;
      cnt <= cnt + (Q_AW+1)'(acc) - (Q_AW+1)'(take);
    end
  end

endmodule

### hdl/pvm_cordic.sv
// Pipelined rotation-mode CORDIC, one stage register per iteration.
module pvm_cordic (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  pvm_pkg::cmd_t                in_item,
  output logic                         out_valid,
  output logic signed [pvm_pkg::XW-1:0] out_x,
  output logic signed [pvm_pkg::XW-1:0] out_y,
  output pvm_pkg::cmd_t                out_item
);
  import pvm_pkg::*;

  logic signed [XW-1:0] xs [STAGES+1];
  logic signed [XW-1:0] ys [STAGES+1];
  logic signed [XW-1:0] zs [STAGES+1];
  cmd_t                 its [STAGES+1];
  logic                 vs [STAGES+1];

  always_ff @(posedge clk) begin
    xs[0]  <= X_INIT;
    ys[0]  <= '0;
    zs[0]  <= {{(XW-32){in_item.ang[15]}}, in_item.ang, 16'b0};
    its[0] <= in_item;
    if (rst) vs[0] <= 1'b0;
    else     vs[0] <= in_valid;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    assign dx = xs[i] >>> i;
    assign dy = ys[i] >>> i;
    always_ff @(posedge clk) begin
      if (!zs[i][XW-1]) begin
        xs[i+1] <= xs[i] - dy;
        ys[i+1] <= ys[i] + dx;
        zs[i+1] <= zs[i] - ATAN_TABLE[i];
      end else begin
        xs[i+1] <= xs[i] + dy;
        ys[i+1] <= ys[i] - dx;
        zs[i+1] <= zs[i] + ATAN_TABLE[i];
      end
      its[i+1] <= its[i];
      if (rst) vs[i+1] <= 1'b0;
      else     vs[i+1] <= vs[i];
    end
  end

  assign out_valid = vs[STAGES];
  assign out_x     = xs[STAGES];
  assign out_y     = ys[STAGES];
  assign out_item  = its[STAGES];

endmodule

### hdl/pvm_back.sv
// Back end: CORDIC, matrix build, matrix-vector product, rounding, clip and result queue.
module pvm_back (
  input  logic               clk,
  input  logic               rst,
  input  pvm_pkg::qctl_t     q_ctl,
  input  pvm_pkg::cmd_t      q_item,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic               saturated
);
  import pvm_pkg::*;

  logic [OUT_AW:0]   credit;
  logic              issue;
  logic              take;

  logic              cv;
  logic signed [XW-1:0] cx;
  logic signed [XW-1:0] cy;
  cmd_t              citem;

  // c/s stage
  logic              v1;
  logic signed [CW-1:0] c1, s1;
  logic signed [15:0] gn1, gt1, vx1, vy1;
  logic signed [XW-1:0] cr, sr;
  // squares
  logic              v2;
  logic signed [PW-1:0] cc2, ss2, cs2;
  logic signed [16:0] gd2;
  logic signed [15:0] gn2, gt2, vx2, vy2;
  // gain products
  logic              v3;
  logic signed [PW+15:0] a3, b3, e3, f3;
  logic signed [PW+16:0] d3;
  logic signed [15:0] vx3, vy3;
  // matrix entries
  logic              v4;
  logic signed [MW-1:0] m00, m01, m11;
  logic signed [15:0] vx4, vy4;
  // vector products
  logic              v5;
  logic signed [MW+15:0] p0, p1, p2, p3;
  // sums
  logic signed [MW+17:0] sx, sy, rx, ry;
  logic signed [MW+17:0] lo, hi;
  logic signed [15:0] ox, oy;
  logic              satx, saty;

  res_t              omem [OUT_DEPTH];
  logic [OUT_AW-1:0] wptr, rptr;
  logic [OUT_AW:0]   ocnt;

  // issue only with room reserved in the result queue for everything in flight
  assign issue = q_ctl.valid && (credit < (OUT_AW+1)'(OUT_DEPTH));
  assign q_pop = issue;
  assign take  = pop && !empty;

  pvm_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (issue),
    .in_item   (q_item),
    .out_valid (cv),
    .out_x     (cx),
    .out_y     (cy),
    .out_item  (citem)
  );

  assign cr = (cx + XW'(32768)) >>> 16;
  assign sr = (cy + XW'(32768)) >>> 16;

  assign lo = -(MW+18)'(32768);
  assign hi = (MW+18)'(32767);

  always_comb begin
    sx = (MW+18)'(p0) + (MW+18)'(p1) + ((MW+18)'(1) <<< 39);
    sy = (MW+18)'(p2) + (MW+18)'(p3) + ((MW+18)'(1) <<< 39);
    rx = sx >>> 40;
    ry = sy >>> 40;
    satx = 1'b0;
    saty = 1'b0;
    ox = rx[15:0];
    oy = ry[15:0];
    if (rx > hi) begin
      ox = 16'sh7FFF; satx = 1'b1;
    end else if (rx < lo) begin
      ox = -16'sh8000; satx = 1'b1;
    end
    if (ry > hi) begin
      oy = 16'sh7FFF; saty = 1'b1;
    end else if (ry < lo) begin
      oy = -16'sh8000; saty = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    // round c and s to Q2.14, undo the half-turn fold
    c1 <= citem.flip ? -cr[CW-1:0] : cr[CW-1:0];
    s1 <= citem.flip ? -sr[CW-1:0] : sr[CW-1:0];
    gn1 <= citem.gn; gt1 <= citem.gt; vx1 <= citem.vx; vy1 <= citem.vy;

    cc2 <= PW'(c1 * c1);
    ss2 <= PW'(s1 * s1);
    cs2 <= PW'(c1 * s1);
    gd2 <= 17'(gt1) - 17'(gn1);
    gn2 <= gn1; gt2 <= gt1; vx2 <= vx1; vy2 <= vy1;

    a3 <= cc2 * gt2;
    b3 <= ss2 * gn2;
    d3 <= cs2 * gd2;
    e3 <= ss2 * gt2;
    f3 <= cc2 * gn2;
    vx3 <= vx2; vy3 <= vy2;

    m00 <= MW'(a3) + MW'(b3);
    m01 <= MW'(d3);
    m11 <= MW'(e3) + MW'(f3);
    vx4 <= vx3; vy4 <= vy3;

    p0 <= m00 * vx4;
    p1 <= m01 * vy4;
    p2 <= m01 * vx4;
    p3 <= m11 * vy4;

    if (v5) omem[wptr] <= '{ox: ox, oy: oy, sat: satx | saty};

    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      wptr <= '0; rptr <= '0; ocnt <= '0; credit <= '0;
    end else begin
      v1 <= cv; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      if (v5)   wptr <= wptr + 1'b1;
      if (take) rptr <= rptr + 1'b1;
      ocnt   <= ocnt + (OUT_AW+1)'(v5) - (OUT_AW+1)'(take);
      credit <= credit + (OUT_AW+1)'(issue) - (OUT_AW+1)'(take);
    end
  end

  assign empty     = (ocnt == '0);
  assign out_x     = omem[rptr].ox;
  assign out_y     = omem[rptr].oy;
  assign saturated = omem[rptr].sat;

endmodule

### hdl/planar_velocity_modulation_core.sv
// Top level of the planar velocity modulation core.
//
// Input channel: drive angle, gain_normal, gain_tangent, speed_x, speed_y and
// raise push; the item is taken on a clock edge where push is high and full
// is low. Result channel: while empty is low, out_x, out_y and saturated show
// the oldest result; raise pop to take it.
//
// Each item gives one result: M*v with M = E*D*E, E the reflection built from
// cos and sin of the angle, rounded half up and clipped to Q8.8.
// Throughput: one item per cycle, sustained while the receiver pops results.
// From accept to result visible, the CORDIC load register takes the item
// straight from the input queue, then one per CORDIC iteration, then rounding
// of c/s, squares, gain products, matrix sums, vector products, and the final
// add/clip that writes the result queue.
// The back end issues an item only while the result queue has a slot reserved
// for it, so a stalled receiver fills the result queue, then the input queue,
// and then full rises; nothing is dropped.
// Reset (rst, synchronous) empties both queues and the pipeline valids.
module planar_velocity_modulation_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] angle,
  input  logic signed [15:0] gain_normal,
  input  logic signed [15:0] gain_tangent,
  input  logic signed [15:0] speed_x,
  input  logic signed [15:0] speed_y,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic               saturated
);
  import pvm_pkg::*;

  qctl_t q_ctl;
  cmd_t  q_item;
  logic  q_pop;

  // front: fold angle, hold items until the back end issues them
  pvm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .angle        (angle),
    .gain_normal  (gain_normal),
    .gain_tangent (gain_tangent),
    .speed_x      (speed_x),
    .speed_y      (speed_y),
    .q_pop        (q_pop),
    .q_ctl        (q_ctl),
    .q_item       (q_item)
  );

  // back: arithmetic pipeline and result queue
  pvm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_ctl     (q_ctl),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_x     (out_x),
    .out_y     (out_y),
    .saturated (saturated)
  );

endmodule
